// ===== src/biphase_ir_frame_encoder_core_macros.svh =====
// Assertion macros shared by the biphase IR frame encoder RTL.
`ifndef BIPHASE_IR_FRAME_ENCODER_CORE_MACROS_SVH
`define BIPHASE_IR_FRAME_ENCODER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define BIFE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on clk, off during reset.
`define BIFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BIFE_ASSERT_SAME(label, ante, cons, msg)
`define BIFE_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== src/bife_pkg.sv =====
// Shared widths, register indexes and types of the biphase IR frame encoder.
package bife_pkg;

    localparam int HALF_PERIOD_W = 12;
    localparam int DEVICE_CODE_W = 13;
    localparam int COMMAND_W     = 6;
    localparam int DURATION_W    = 13;
    localparam int TOTAL_W       = 18;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 13;

    localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RESET = 12'd320;
    localparam logic [DEVICE_CODE_W-1:0] DEVICE_CODE_RESET = 13'd0;

    localparam logic [CFG_INDEX_W-1:0] REG_HALF_PERIOD = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_CODE = 1'b1;

    // One biphase half bit handed from the frame shifter to the run merger.
    typedef struct packed {
        logic valid;
        logic level;
        logic tail;
    } half_t;

endpackage

// ===== src/biphase_ir_frame_encoder_core.sv =====
// Top level of the biphase IR frame encoder: config registers, frame shifter, run merger.
//
// Channel   | Direction | Transfer when         | Payload
// ----------+-----------+-----------------------+------------------------------------------
// request   | in        | start && !busy        | command_code, repeat_frame
// config    | in        | cfg_write             | cfg_index, cfg_data
// result    | out       | result_strobe         | pulse_level, duration, last, frame_total
//
// A frame holds F = DEVICE_BITS + COMMAND_BITS + 4 bits. After the request transfer,
// the frame shift register hands one biphase half bit per cycle to the run merger,
// and a flush step then emits the trailing run; busy stays high until the flush is
// done, so no request is taken before that. Results appear as they form, at
// most one per cycle. Reset clears control state and loads half_period = 320 and
// device_code = 0. The result side cannot stall, so busy depends only on the frame.
`include "biphase_ir_frame_encoder_core_macros.svh"

module biphase_ir_frame_encoder_core #(
    parameter int DEVICE_BITS  = 13,
    parameter int COMMAND_BITS = 6
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [bife_pkg::COMMAND_W-1:0]   command_code,
    input  logic                             repeat_frame,
    input  logic                             cfg_write,
    input  logic [bife_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bife_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                             result_strobe,
    output logic                             pulse_level,
    output logic [bife_pkg::DURATION_W-1:0]  duration,
    output logic                             last,
    output logic [bife_pkg::TOTAL_W-1:0]     frame_total
);
    import bife_pkg::*;

    logic [HALF_PERIOD_W-1:0] half_period_reg, half_period_next;
    logic [DEVICE_CODE_W-1:0] device_code_reg, device_code_next;

    logic  accept;
    half_t half;
    logic  flush_pending;

    // The user must issue register writes only while idle; the block does not guard this.
    always_comb
    begin
        half_period_next = half_period_reg;
        device_code_next = device_code_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_HALF_PERIOD: half_period_next = cfg_data[HALF_PERIOD_W-1:0];
                REG_DEVICE_CODE: device_code_next = cfg_data[DEVICE_CODE_W-1:0];
                default:         half_period_next = half_period_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
            device_code_reg <= DEVICE_CODE_RESET;
        end
        else
        begin
            half_period_reg <= half_period_next;
            device_code_reg <= device_code_next;
        end
    end

    // Accept a request only when neither the shifter nor the flush is in flight.
    assign busy   = half.valid || flush_pending;
    assign accept = start && !busy;

    bife_frame_sreg #(
        .DEVICE_BITS  (DEVICE_BITS),
        .COMMAND_BITS (COMMAND_BITS)
    ) u_sreg (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept),
        .device_code  (device_code_reg),
        .command_code (command_code),
        .repeat_frame (repeat_frame),
        .half         (half)
    );

    // Merge halves into pulse/space runs; drop nothing, hold the open run.
    bife_run_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .clear         (accept),
        .half          (half),
        .half_period   (half_period_reg),
        .flush_pending (flush_pending),
        .result_strobe (result_strobe),
        .pulse_level   (pulse_level),
        .duration      (duration),
        .last          (last),
        .frame_total   (frame_total)
    );

    // The closing run is always a single half, since a bit's halves differ.
    `BIFE_ASSERT_SAME(a_last_single_half, result_strobe && last,
        duration == DURATION_W'(half_period_reg), "final run is not one half period")
    `BIFE_ASSERT_SAME(a_total_only_on_last, result_strobe && !last,
        frame_total == '0, "frame total shown on a non-final result")
    `BIFE_ASSERT_SAME(a_mid_result_busy, result_strobe && !last,
        busy, "non-final result while idle")
    `BIFE_ASSERT_NEXT(a_accept_busy, start && !busy,
        busy, "busy not raised after a request transfer")

endmodule

// ===== src/bife_frame_sreg.sv =====
// Frame shift register: builds the bit frame and walks it one half bit per cycle.
module bife_frame_sreg #(
    parameter int DEVICE_BITS  = 13,
    parameter int COMMAND_BITS = 6
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               load,
    input  logic [bife_pkg::DEVICE_CODE_W-1:0] device_code,
    input  logic [bife_pkg::COMMAND_W-1:0]     command_code,
    input  logic                               repeat_frame,
    output bife_pkg::half_t                    half
);
    import bife_pkg::*;

    localparam int FRAME_BITS = DEVICE_BITS + COMMAND_BITS + 4;
    localparam int CNT_W      = $clog2(FRAME_BITS + 1);
    localparam int DEV_EXT_W  = (DEVICE_BITS > DEVICE_CODE_W) ? DEVICE_BITS : DEVICE_CODE_W;
    localparam int CMD_EXT_W  = (COMMAND_BITS > COMMAND_W) ? COMMAND_BITS : COMMAND_W;

    logic [DEV_EXT_W-1:0]  dev_ext;
    logic [CMD_EXT_W-1:0]  cmd_ext;
    logic [FRAME_BITS-1:0] frame_load;

    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  phase_reg, phase_next;
    logic                  active;

    // Missing high bits of a wide field go out as zero.
    assign dev_ext    = DEV_EXT_W'(device_code);
    assign cmd_ext    = CMD_EXT_W'(command_code);
    assign frame_load = {1'b1, dev_ext[DEVICE_BITS-1:0], repeat_frame, 1'b0,
                         cmd_ext[COMMAND_BITS-1:0], ~command_code[0]};

    assign active = (cnt_reg != '0);

    always_comb
    begin
        frame_next = frame_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        if (load)
        begin
            frame_next = frame_load;
            cnt_next   = CNT_W'(FRAME_BITS);
            phase_next = 1'b0;
        end
        else if (active)
        begin
            phase_next = ~phase_reg;
            if (phase_reg)
            begin
                frame_next = {frame_reg[FRAME_BITS-2:0], 1'b0};
                cnt_next   = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

    // First half carries the bit, second half its inverse.
    assign half.valid = active;
    assign half.level = frame_reg[FRAME_BITS-1] ^ phase_reg;
    assign half.tail  = phase_reg && (cnt_reg == CNT_W'(1));

endmodule

// ===== src/bife_run_merge.sv =====
// Run merger: joins equal adjacent halves into durations and registers each result.
module bife_run_merge (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               clear,
    input  bife_pkg::half_t                    half,
    input  logic [bife_pkg::HALF_PERIOD_W-1:0] half_period,
    output logic                               flush_pending,
    output logic                               result_strobe,
    output logic                               pulse_level,
    output logic [bife_pkg::DURATION_W-1:0]    duration,
    output logic                               last,
    output logic [bife_pkg::TOTAL_W-1:0]       frame_total
);
    import bife_pkg::*;

    logic                  have_reg, have_next;
    logic                  level_reg, level_next;
    logic [DURATION_W-1:0] len_reg, len_next;
    logic [TOTAL_W-1:0]    total_reg, total_next;
    logic                  flush_reg, flush_next;

    logic                  strobe_reg, strobe_next;
    logic                  out_level_reg, out_level_next;
    logic [DURATION_W-1:0] out_dur_reg, out_dur_next;
    logic                  out_last_reg, out_last_next;
    logic [TOTAL_W-1:0]    out_total_reg, out_total_next;

    logic [DURATION_W-1:0] hp_ext;

    assign hp_ext = DURATION_W'(half_period);

    always_comb
    begin
        have_next      = have_reg;
        level_next     = level_reg;
        len_next       = len_reg;
        total_next     = total_reg;
        flush_next     = flush_reg;
        strobe_next    = 1'b0;
        out_level_next = out_level_reg;
        out_dur_next   = out_dur_reg;
        out_last_next  = out_last_reg;
        out_total_next = out_total_reg;
        if (clear)
        begin
            have_next  = 1'b0;
            total_next = '0;
            flush_next = 1'b0;
        end
        else if (flush_reg)
        begin
            // Flush the trailing run with the frame total.
            strobe_next    = 1'b1;
            out_level_next = level_reg;
            out_dur_next   = len_reg;
            out_last_next  = 1'b1;
            out_total_next = total_reg + TOTAL_W'(len_reg);
            total_next     = out_total_next;
            have_next      = 1'b0;
            flush_next     = 1'b0;
        end
        else if (half.valid)
        begin
            if (have_reg && (level_reg == half.level))
            begin
                len_next = len_reg + hp_ext;
            end
            else
            begin
                if (have_reg)
                begin
                    strobe_next    = 1'b1;
                    out_level_next = level_reg;
                    out_dur_next   = len_reg;
                    out_last_next  = 1'b0;
                    out_total_next = '0;
                    total_next     = total_reg + TOTAL_W'(len_reg);
                end
                have_next  = 1'b1;
                level_next = half.level;
                len_next   = hp_ext;
            end
            if (half.tail)
            begin
                flush_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg   <= 1'b0;
            flush_reg  <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            have_reg   <= have_next;
            flush_reg  <= flush_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg     <= level_next;
        len_reg       <= len_next;
        total_reg     <= total_next;
        out_level_reg <= out_level_next;
        out_dur_reg   <= out_dur_next;
        out_last_reg  <= out_last_next;
        out_total_reg <= out_total_next;
    end

    assign flush_pending = flush_reg;
    assign result_strobe = strobe_reg;
    assign pulse_level   = out_level_reg;
    assign duration      = out_dur_reg;
    assign last          = out_last_reg;
    assign frame_total   = out_total_reg;

endmodule
